// ===== rtl/distance_vector_table_update_top_macros.svh =====
// assertion helpers shared by the rtl files of the distance-vector table
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_TOP_MACROS_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define DVTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define DVTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dvtu_pkg.sv =====
package dvtu_pkg;

  // parameter defaults
  localparam int MAX_NODES_DEF      = 16;
  localparam int MAX_NEIGHBOURS_DEF = 8;
  localparam int INFINITY_COST_DEF  = 999;

  // field widths
  localparam int OP_W       = 3;
  localparam int SLOT_W     = 4;
  localparam int ID_W       = 8;
  localparam int COST_W     = 16;
  localparam int STAT_W     = 2;
  localparam int NODE_CNT_W = 5;
  localparam int NB_CNT_W   = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // op codes
  localparam logic [OP_W-1:0] OP_DEF_ROW   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEF_COL   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_COST  = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_COST  = 3'd3;
  localparam logic [OP_W-1:0] OP_ROUTE_UPD = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_ROW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_COL = 2'd2;

  // config register indexes, byte address = 4 * index
  localparam logic [REG_IDX_W-1:0] REG_SELF_ID   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NB_COUNT  = 2'd2;

  // datapath step commanded by the controller
  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_MATCH,
    STEP_FIND,
    STEP_ROW_SWEEP,
    STEP_COL_SWEEP,
    STEP_SET,
    STEP_GET_RD,
    STEP_GET_DATA,
    STEP_VIA_RD,
    STEP_OWN_RD,
    STEP_RELAX,
    STEP_ROWMIN,
    STEP_DONE
  } step_t;

  typedef struct packed {
    step_t step;
    logic  capture;
    logic  res_load;
  } dvtu_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            slot_row_ok;
    logic            slot_col_ok;
    logic            row_found;
    logic            to_found;
    logic            sweep_last;
  } dvtu_sts_t;

endpackage

// ===== rtl/dvtu_ram.sv =====
module dvtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/dvtu_ctrl.sv =====
`include "distance_vector_table_update_top_macros.svh"

module dvtu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dvtu_pkg::dvtu_cmd_t cmd,
  input  dvtu_pkg::dvtu_sts_t sts
);

  import dvtu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_FIND,
    S_ROW_SWEEP,
    S_COL_SWEEP,
    S_SET,
    S_GET_RD,
    S_GET_DATA,
    S_VIA_RD,
    S_OWN_RD,
    S_RELAX,
    S_ROWMIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   load;

  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MATCH;
      end
      S_MATCH: state_next = S_FIND;
      S_FIND: begin
        case (sts.op)
          OP_DEF_ROW:   state_next = sts.slot_row_ok ? S_ROW_SWEEP : S_DONE;
          OP_DEF_COL:   state_next = sts.slot_col_ok ? S_COL_SWEEP : S_DONE;
          OP_SET_COST:  state_next = (sts.row_found && sts.to_found) ? S_SET : S_DONE;
          OP_GET_COST:  state_next = (sts.row_found && sts.to_found) ? S_GET_RD : S_DONE;
          OP_ROUTE_UPD: state_next = sts.to_found ? S_VIA_RD : S_DONE;
          default:      state_next = S_DONE;
        endcase
      end
      S_ROW_SWEEP, S_COL_SWEEP: begin
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_SET:      state_next = S_DONE;
      S_GET_RD:   state_next = S_GET_DATA;
      S_GET_DATA: state_next = S_DONE;
      S_VIA_RD:   state_next = S_OWN_RD;
      S_OWN_RD:   state_next = S_RELAX;
      S_RELAX:    state_next = S_ROWMIN;
      S_ROWMIN:   state_next = S_DONE;
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.capture  = in_valid && in_ready;
    cmd.res_load = load;
    case (state)
      S_IDLE:      cmd.step = STEP_IDLE;
      S_MATCH:     cmd.step = STEP_MATCH;
      S_FIND:      cmd.step = STEP_FIND;
      S_ROW_SWEEP: cmd.step = STEP_ROW_SWEEP;
      S_COL_SWEEP: cmd.step = STEP_COL_SWEEP;
      S_SET:       cmd.step = STEP_SET;
      S_GET_RD:    cmd.step = STEP_GET_RD;
      S_GET_DATA:  cmd.step = STEP_GET_DATA;
      S_VIA_RD:    cmd.step = STEP_VIA_RD;
      S_OWN_RD:    cmd.step = STEP_OWN_RD;
      S_RELAX:     cmd.step = STEP_RELAX;
      S_ROWMIN:    cmd.step = STEP_ROWMIN;
      S_DONE:      cmd.step = STEP_DONE;
      default:     cmd.step = STEP_IDLE;
    endcase
  end

  `DVTU_ASSERT_NXT(a_load_shows, cmd.res_load, out_valid, "loaded result not valid")
  `DVTU_ASSERT_NXT(a_accept_starts, in_valid && in_ready, cmd.step == STEP_MATCH,
    "accepted beat did not start a match")
  `DVTU_ASSERT_NXT(a_done_holds, state == S_DONE && out_valid && !out_ready,
    state == S_DONE, "finished op left done while output stalled")

endmodule

// ===== rtl/dvtu_datapath.sv =====
`include "distance_vector_table_update_top_macros.svh"

module dvtu_datapath #(
  parameter int MAX_NODES      = dvtu_pkg::MAX_NODES_DEF,
  parameter int MAX_NEIGHBOURS = dvtu_pkg::MAX_NEIGHBOURS_DEF,
  parameter int INFINITY_COST  = dvtu_pkg::INFINITY_COST_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dvtu_pkg::dvtu_cmd_t               cmd,
  output dvtu_pkg::dvtu_sts_t               sts,
  input  logic [dvtu_pkg::ID_W-1:0]         self_id,
  input  logic [dvtu_pkg::NODE_CNT_W-1:0]   col_count,
  input  logic [dvtu_pkg::NB_CNT_W-1:0]     neighbour_count,
  input  logic [dvtu_pkg::OP_W-1:0]         op,
  input  logic [dvtu_pkg::SLOT_W-1:0]       slot,
  input  logic [dvtu_pkg::ID_W-1:0]         from_node,
  input  logic [dvtu_pkg::ID_W-1:0]         to_node,
  input  logic [dvtu_pkg::COST_W-1:0]       cost,
  output logic [dvtu_pkg::STAT_W-1:0]       status,
  output logic [dvtu_pkg::COST_W-1:0]       cost_out,
  output logic                              route_changed,
  output logic [dvtu_pkg::ID_W-1:0]         next_hop
);

  import dvtu_pkg::*;

  localparam int ROWS   = MAX_NEIGHBOURS + 1;
  localparam int COL_W  = $clog2(MAX_NODES);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam logic [COST_W-1:0] INF = COST_W'(INFINITY_COST);

  // latched command
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ID_W-1:0]   from_q;
  logic [ID_W-1:0]   to_q;
  logic [COST_W-1:0] cost_q;

  // id stores, row zero is self_id
  logic [ID_W-1:0]      column_ids [MAX_NODES];
  logic [ID_W-1:0]      row_ids [1:MAX_NEIGHBOURS];
  logic [MAX_NODES-1:0] hop_valid;

  // match vectors and first-hit indexes
  logic [MAX_NODES-1:0] to_hit, from_hit, to_hit_q, from_hit_q;
  logic [ROWS-1:0]      row_hit, row_hit_q;
  logic [COL_W-1:0]     to_idx, from_idx, to_idx_q, from_idx_q;
  logic [ROW_W-1:0]     row_idx, row_idx_q;
  logic                 from_found;

  logic [CNT_W-1:0]  sweep_cnt;
  logic [ROW_W-1:0]  slot_row;
  logic [COL_W-1:0]  slot_col;
  logic [COST_W-1:0] own_def;

  // relaxation
  logic [COST_W-1:0] via_q;
  logic [COST_W-1:0] own_q;
  logic              hop_vld_q;
  logic [COST_W:0]   sum_full;
  logic [COST_W-1:0] sum_sat;
  logic              improved;
  logic              row_zero;
  logic [COST_W-1:0] row_val;
  logic              row_lower;

  logic [COST_W-1:0] res_cost_q;
  logic              res_changed_q;
  logic [ID_W-1:0]   res_hop_q;
  logic [STAT_W-1:0] stat_calc;

  // memory ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_wa, ram_ra;
  logic [COST_W-1:0] ram_wd, ram_rd;
  logic              hop_we, hop_re;
  logic [ID_W-1:0]   hop_rd;

  always_comb begin
    row_hit[0] = (self_id == from_q);
    for (int i = 1; i <= MAX_NEIGHBOURS; i++) begin
      row_hit[i] = (int'(neighbour_count) >= i) && (row_ids[i] == from_q);
    end
    for (int j = 0; j < MAX_NODES; j++) begin
      to_hit[j]   = (int'(col_count) > j) && (column_ids[j] == to_q);
      from_hit[j] = (int'(col_count) > j) && (column_ids[j] == from_q);
    end
  end

  // first match wins
  always_comb begin
    to_idx   = '0;
    from_idx = '0;
    row_idx  = '0;
    for (int j = MAX_NODES - 1; j >= 0; j--) begin
      if (to_hit_q[j]) to_idx = COL_W'(j);
      if (from_hit_q[j]) from_idx = COL_W'(j);
    end
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (row_hit_q[i]) row_idx = ROW_W'(i);
    end
  end

  assign from_found = |from_hit_q;
  assign slot_row   = ROW_W'(slot_q);
  assign slot_col   = COL_W'(slot_q);
  assign own_def    = (to_q == self_id) ? '0 : cost_q;

  assign sum_full  = {1'b0, via_q} + {1'b0, cost_q};
  assign sum_sat   = sum_full[COST_W] ? COST_MAX : sum_full[COST_W-1:0];
  assign improved  = (cmd.step == STEP_RELAX) && (sum_sat < ram_rd);
  assign row_zero  = (row_idx_q == '0);
  assign row_val   = row_zero ? own_q : ram_rd;
  assign row_lower = sts.row_found && (row_val > cost_q);

  always_comb begin
    sts.op          = op_q;
    sts.slot_row_ok = (slot_q != '0) && (int'(slot_q) <= MAX_NEIGHBOURS);
    sts.slot_col_ok = (int'(slot_q) < MAX_NODES);
    sts.row_found   = |row_hit_q;
    sts.to_found    = |to_hit_q;
    if (op_q == OP_DEF_ROW) begin
      sts.sweep_last = (sweep_cnt == CNT_W'(MAX_NODES - 1));
    end else begin
      sts.sweep_last = (sweep_cnt == CNT_W'(MAX_NEIGHBOURS));
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = '0;
    ram_wd = INF;
    ram_re = 1'b0;
    ram_ra = '0;
    hop_we = 1'b0;
    hop_re = 1'b0;
    case (cmd.step)
      STEP_ROW_SWEEP: begin
        ram_we = 1'b1;
        ram_wa = {slot_row, COL_W'(sweep_cnt)};
      end
      STEP_COL_SWEEP: begin
        ram_we = 1'b1;
        ram_wa = {ROW_W'(sweep_cnt), slot_col};
        ram_wd = (sweep_cnt == '0) ? own_def : INF;
      end
      STEP_SET: begin
        ram_we = 1'b1;
        ram_wa = {row_idx_q, to_idx_q};
        ram_wd = cost_q;
      end
      STEP_GET_RD: begin
        ram_re = 1'b1;
        ram_ra = {row_idx_q, to_idx_q};
      end
      STEP_VIA_RD: begin
        ram_re = 1'b1;
        ram_ra = {{ROW_W{1'b0}}, from_idx_q};
      end
      STEP_OWN_RD: begin
        ram_re = 1'b1;
        ram_ra = {{ROW_W{1'b0}}, to_idx_q};
        hop_re = 1'b1;
      end
      STEP_RELAX: begin
        ram_we = improved;
        ram_wa = {{ROW_W{1'b0}}, to_idx_q};
        ram_wd = sum_sat;
        ram_re = 1'b1;
        ram_ra = {row_idx_q, to_idx_q};
        hop_we = improved;
      end
      STEP_ROWMIN: begin
        ram_we = row_lower;
        ram_wa = {row_idx_q, to_idx_q};
        ram_wd = cost_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_calc = STAT_OK;
    if (op_q inside {OP_SET_COST, OP_GET_COST}) begin
      if (!sts.row_found) stat_calc = STAT_NO_ROW;
      else if (!sts.to_found) stat_calc = STAT_NO_COL;
    end else if (op_q == OP_ROUTE_UPD) begin
      if (!sts.to_found) stat_calc = STAT_NO_COL;
      else if (!sts.row_found) stat_calc = STAT_NO_ROW;
    end
  end

  // id stores and hop valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        column_ids[j] <= '0;
      end
      for (int i = 1; i <= MAX_NEIGHBOURS; i++) begin
        row_ids[i] <= '0;
      end
      hop_valid <= '0;
      sweep_cnt <= '0;
    end else begin
      case (cmd.step)
        STEP_FIND: sweep_cnt <= '0;
        STEP_ROW_SWEEP: begin
          row_ids[slot_row] <= from_q;
          sweep_cnt         <= sweep_cnt + 1'b1;
        end
        STEP_COL_SWEEP: begin
          column_ids[slot_col] <= to_q;
          sweep_cnt            <= sweep_cnt + 1'b1;
        end
        STEP_RELAX: begin
          if (improved) hop_valid[to_idx_q] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      slot_q <= slot;
      from_q <= from_node;
      to_q   <= to_node;
      cost_q <= cost;
    end
    to_hit_q   <= to_hit;
    from_hit_q <= from_hit;
    row_hit_q  <= row_hit;
    to_idx_q   <= to_idx;
    from_idx_q <= from_idx;
    row_idx_q  <= row_idx;

    case (cmd.step)
      STEP_FIND: begin
        if (op_q == OP_DEF_COL && sts.slot_col_ok) begin
          res_cost_q <= own_def;
        end else if (op_q inside {OP_SET_COST, OP_GET_COST, OP_ROUTE_UPD}) begin
          res_cost_q <= INF;
        end else begin
          res_cost_q <= '0;
        end
        res_changed_q <= 1'b0;
        res_hop_q     <= '0;
      end
      STEP_SET:      res_cost_q <= cost_q;
      STEP_GET_DATA: res_cost_q <= ram_rd;
      STEP_OWN_RD: begin
        via_q     <= from_found ? ram_rd : INF;
        hop_vld_q <= hop_valid[to_idx_q];
      end
      STEP_RELAX: begin
        own_q         <= improved ? sum_sat : ram_rd;
        res_changed_q <= improved;
        if (improved) begin
          res_hop_q <= from_q;
        end else begin
          res_hop_q <= hop_vld_q ? hop_rd : '0;
        end
      end
      STEP_ROWMIN: res_cost_q <= (row_zero && row_lower) ? cost_q : own_q;
      default: begin
      end
    endcase

    if (cmd.res_load) begin
      status        <= stat_calc;
      cost_out      <= res_cost_q;
      route_changed <= res_changed_q;
      next_hop      <= res_hop_q;
    end
  end

  dvtu_ram #(
    .WIDTH (COST_W),
    .DEPTH (ROWS << COL_W)
  ) u_cost_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  dvtu_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_NODES)
  ) u_hop_ram (
    .clk     (clk),
    .wr_en   (hop_we),
    .wr_addr (to_idx_q),
    .wr_data (from_q),
    .rd_en   (hop_re),
    .rd_addr (to_idx_q),
    .rd_data (hop_rd)
  );

  `DVTU_ASSERT_IMP(a_sweep_slot,
    cmd.step == STEP_ROW_SWEEP || cmd.step == STEP_COL_SWEEP,
    (cmd.step == STEP_ROW_SWEEP) ? sts.slot_row_ok : sts.slot_col_ok,
    "table sweep on an out of range slot")
  `DVTU_ASSERT_IMP(a_access_hit, cmd.step == STEP_SET || cmd.step == STEP_GET_RD,
    sts.row_found && sts.to_found, "cost access without row and column match")
  `DVTU_ASSERT_IMP(a_relax_order, cmd.step == STEP_RELAX,
    $past(cmd.step) == STEP_OWN_RD && sts.to_found, "relax step out of order")

endmodule

// ===== rtl/distance_vector_table_update_top.sv =====
// distance-vector cost table with bellman-ford style route relaxation
//
// channels: input beats (op, slot, from_node, to_node, cost) on in_valid/in_ready,
// one result beat per input (status, cost_out, route_changed, next_hop) on
// out_valid/out_ready. registers self_id, col_count, neighbour_count sit on
// the apb port at byte addresses 0, 4 and 8; write them only while idle.
// one op is worked at a time; in_ready is high only while the sequencer idles.
// the cost table has one read and one write port, so every sweep write and
// every read is a step of its own: after accept the sequencer matches ids,
// picks the branch, works the op's sweep, access or relax steps, hands the
// result over in done and goes back to idle.
// the result sits in an output register, so a stalled receiver only holds the
// finished op; the block can take the next beat once that op is handed over.
// reset (synchronous) clears the id tables, next hops, self_id, neighbour_count
// and out_valid and sets col_count to 16; cost cells hold no value until written.
module distance_vector_table_update_top #(
  parameter int MAX_NODES      = dvtu_pkg::MAX_NODES_DEF,
  parameter int MAX_NEIGHBOURS = dvtu_pkg::MAX_NEIGHBOURS_DEF,
  parameter int INFINITY_COST  = dvtu_pkg::INFINITY_COST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // apb config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dvtu_pkg::PADDR_W-1:0]  paddr,
  input  logic [dvtu_pkg::PDATA_W-1:0]  pwdata,
  output logic [dvtu_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dvtu_pkg::OP_W-1:0]     op,
  input  logic [dvtu_pkg::SLOT_W-1:0]   slot,
  input  logic [dvtu_pkg::ID_W-1:0]     from_node,
  input  logic [dvtu_pkg::ID_W-1:0]     to_node,
  input  logic [dvtu_pkg::COST_W-1:0]   cost,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dvtu_pkg::STAT_W-1:0]   status,
  output logic [dvtu_pkg::COST_W-1:0]   cost_out,
  output logic                          route_changed,
  output logic [dvtu_pkg::ID_W-1:0]     next_hop
);

  import dvtu_pkg::*;

  localparam logic [NODE_CNT_W-1:0] COL_COUNT_RST = 5'd16;

  logic [ID_W-1:0]       self_id;
  logic [NODE_CNT_W-1:0] col_count;
  logic [NB_CNT_W-1:0]   neighbour_count;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_idx;

  dvtu_cmd_t cmd;
  dvtu_sts_t sts;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  // register index = paddr[3:2]
  assign cfg_idx = paddr[3:2];

  // config registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id         <= '0;
      col_count       <= COL_COUNT_RST;
      neighbour_count <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SELF_ID:   self_id         <= pwdata[ID_W-1:0];
        REG_COL_COUNT: col_count       <= pwdata[NODE_CNT_W-1:0];
        REG_NB_COUNT:  neighbour_count <= pwdata[NB_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      REG_SELF_ID:   prdata = PDATA_W'(self_id);
      REG_COL_COUNT: prdata = PDATA_W'(col_count);
      REG_NB_COUNT:  prdata = PDATA_W'(neighbour_count);
      default:       prdata = '0;
    endcase
  end

  // sequencer: one op at a time, owns both handshakes
  dvtu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // id match, cost table, next hops and the result register
  dvtu_datapath #(
    .MAX_NODES      (MAX_NODES),
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .INFINITY_COST  (INFINITY_COST)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .self_id         (self_id),
    .col_count       (col_count),
    .neighbour_count (neighbour_count),
    .op              (op),
    .slot            (slot),
    .from_node       (from_node),
    .to_node         (to_node),
    .cost            (cost),
    .status          (status),
    .cost_out        (cost_out),
    .route_changed   (route_changed),
    .next_hop        (next_hop)
  );

endmodule
